[rtl/assert_macros.svh]
// assertion macros shared by the adrps modules
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("adrps assertion failed");
`define AST_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adrps assertion failed");
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adrps assertion failed");
`else
`define AST_PROP(lbl, clk, rst, prop)
`define AST_IMPL(lbl, clk, rst, ante, cons)
`define AST_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/adrps_pkg.sv]
// constants and types of the adrp pair reference scanner
// no dependencies
package adrps_pkg;

   localparam int SLOTS          = 8;
   localparam int WINDOW_DEFAULT = 8;
   localparam int CSR_INDEX_W    = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WANTED_TARGET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLLOWER_KIND = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_ANY     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WANTED_REG    = 3'd4;

   localparam logic FOLLOW_ADD = 1'b0;
   localparam logic FOLLOW_LDR = 1'b1;

   typedef struct packed {
      logic [63:0]       wanted_target;
      logic              follower_kind;
      logic              match_any_target;
      logic signed [5:0] wanted_register;
   } cfg_type;

   // everything one word's matches need to be delivered
   typedef struct packed {
      logic [SLOTS-1:0]             hit;
      logic [SLOTS-1:0][SLOTS-1:0]  older;
      logic [SLOTS-1:0][63:0]       target;
      logic [SLOTS-1:0][63:0]       adrp_address;
      logic [63:0]                  follower_address;
      logic [4:0]                   reg_number;
      logic [31:0]                  base_index;
   } hits_type;

endpackage

[rtl/adrps_if.sv]
// request and response channel interfaces of the adrp pair reference scanner
// no dependencies
interface adrps_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] insn_word;
   logic        last_word;

   modport source (output valid, output insn_word, output last_word, input ready);
   modport sink   (input valid, input insn_word, input last_word, output ready);
endinterface

interface adrps_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] adrp_address;
   logic [63:0] follower_address;
   logic [63:0] resolved_target;
   logic [4:0]  reg_number;
   logic [31:0] reference_index;
   logic        last_of_run;

   modport source (output valid, output adrp_address, output follower_address,
                   output resolved_target, output reg_number, output reference_index,
                   output last_of_run, input ready);
   modport sink   (input valid, input adrp_address, input follower_address,
                   input resolved_target, input reg_number, input reference_index,
                   input last_of_run, output ready);
endinterface

[rtl/adrps_window.sv]
// window slots: adrp tracking, follower matching and slot update
// depends on adrps_pkg and assert_macros.svh
`include "assert_macros.svh"

module adrps_window #(
   parameter int WINDOW = adrps_pkg::WINDOW_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  adrps_pkg::cfg_type cfg,
   input  logic [31:0]        word,
   input  logic [63:0]        pc,
   input  logic [31:0]        index_base,
   input  logic               commit,
   input  logic               last,
   output adrps_pkg::hits_type hits,
   output logic               hit_any
);

   localparam int SLOTS  = adrps_pkg::SLOTS;
   localparam int AGE_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = $clog2(SLOTS);

   localparam logic [7:0] ADD_OPC  = 8'h91;
   localparam logic [9:0] LDR_OPC  = 10'h3e5;
   localparam logic [4:0] ADRP_OPC = 5'b10000;

   logic [SLOTS-1:0]            valid_ff, valid_in;
   logic [SLOTS-1:0][4:0]       reg_ff, reg_in;
   logic [SLOTS-1:0][51:0]      page_ff, page_in;
   logic [SLOTS-1:0][AGE_W-1:0] age_ff, age_in;

   logic        add_ok, ldr_ok, follow_ok;
   logic [23:0] off_add, off_ldr, offset;
   logic        is_adrp, reg_ok, open;
   logic [20:0] adrp_imm;
   logic [SLOTS-1:0] hit;

   // follower decode, source and destination must agree
   always_comb begin
      add_ok  = (word[31:24] == ADD_OPC) && !word[23];
      ldr_ok  = (word[31:22] == LDR_OPC);
      off_add = word[22] ? {word[21:10], 12'h000} : {12'h000, word[21:10]};
      off_ldr = {9'd0, word[21:10], 3'b000};
      if (cfg.follower_kind == adrps_pkg::FOLLOW_LDR) begin
         follow_ok = ldr_ok;
         offset    = off_ldr;
      end else begin
         follow_ok = add_ok;
         offset    = off_add;
      end
      follow_ok = follow_ok && (word[4:0] == word[9:5]);
   end

   always_comb begin
      is_adrp  = word[31] && (word[28:24] == ADRP_OPC);
      reg_ok   = cfg.wanted_register[5] || (cfg.wanted_register[4:0] == word[4:0]);
      open     = is_adrp && reg_ok;
      adrp_imm = {word[23:5], word[30:29]};
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         hits.target[i]       = {page_ff[i], 12'h000} + 64'(offset);
         hits.adrp_address[i] = pc - ((64'(age_ff[i]) + 64'd1) << 2);
         hit[i] = follow_ok && valid_ff[i] && (reg_ff[i] == word[4:0]) &&
                  (cfg.match_any_target || (hits.target[i] == cfg.wanted_target));
         for (int j = 0; j < SLOTS; j++) begin
            hits.older[i][j] = age_ff[i] > age_ff[j];
         end
      end
      hits.hit              = hit;
      hits.follower_address = pc;
      hits.reg_number       = word[4:0];
      hits.base_index       = index_base;
      hit_any               = |hit;
   end

   // closes, ageing, then the new adrp takes a free slot or the oldest one; a last word clears all slots
   always_comb begin
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [AGE_W-1:0]  oldest;
      valid_in = valid_ff;
      reg_in   = reg_ff;
      page_in  = page_ff;
      age_in   = age_ff;
      found    = 1'b0;
      slot     = '0;
      oldest   = '0;
      if (commit) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (valid_ff[i] && !hit[i]) begin
               age_in[i]   = age_ff[i] + AGE_W'(1);
               valid_in[i] = age_in[i] < AGE_W'(WINDOW);
            end else begin
               valid_in[i] = 1'b0;
            end
         end
         if (open) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && !valid_in[i]) begin
                  found = 1'b1;
                  slot  = SLOT_W'(i);
               end
            end
            if (!found) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (age_in[i] >= oldest) begin
                     oldest = age_in[i];
                     slot   = SLOT_W'(i);
                  end
               end
            end
            valid_in[slot] = 1'b1;
            reg_in[slot]   = word[4:0];
            page_in[slot]  = pc[63:12] + {{31{adrp_imm[20]}}, adrp_imm};
            age_in[slot]   = '0;
         end
         if (last) begin
            valid_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reg_ff  <= reg_in;
      page_ff <= page_in;
      age_ff  <= age_in;
   end

   `AST_PROP(a_hit_on_open_slot, clock, reset, (hit & ~valid_ff) == '0)
   `AST_NEXT(a_region_end_clears, clock, reset, commit && last, valid_ff == '0)
   `AST_NEXT(a_one_open_per_word, clock, reset, 1'b1,
             $countones(valid_ff) <= $countones($past(valid_ff)) + 1)

endmodule

[rtl/adrps_emit.sv]
// result stage: holds one word's matches and hands them out oldest adrp first
// depends on adrps_pkg, adrps_if and assert_macros.svh
`include "assert_macros.svh"

module adrps_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  adrps_pkg::hits_type load_data,
   output logic                can_load,
   adrps_rsp_if.source         rsp
);

   localparam int SLOTS = adrps_pkg::SLOTS;

   logic [SLOTS-1:0]    mask_ff, mask_in;
   adrps_pkg::hits_type data_ff, data_in;
   logic [31:0]         index_ff, index_in;

   logic [SLOTS-1:0] sel;
   logic             fire, last;
   logic [63:0]      adrp_mux, target_mux;

   // the oldest remaining match is older than every other remaining one
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         sel[i] = mask_ff[i];
         for (int j = 0; j < SLOTS; j++) begin
            if (j != i && mask_ff[j] && !data_ff.older[i][j]) begin
               sel[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      adrp_mux   = '0;
      target_mux = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (sel[i]) begin
            adrp_mux   = adrp_mux | data_ff.adrp_address[i];
            target_mux = target_mux | data_ff.target[i];
         end
      end
   end

   assign fire     = rsp.valid && rsp.ready;
   assign last     = (mask_ff & ~sel) == '0;
   assign can_load = (mask_ff == '0) || (fire && last);

   assign rsp.valid            = |mask_ff;
   assign rsp.adrp_address     = adrp_mux;
   assign rsp.follower_address = data_ff.follower_address;
   assign rsp.resolved_target  = target_mux;
   assign rsp.reg_number       = data_ff.reg_number;
   assign rsp.reference_index  = index_ff;
   assign rsp.last_of_run      = last;

   always_comb begin
      mask_in  = mask_ff;
      index_in = index_ff;
      data_in  = data_ff;
      if (load) begin
         mask_in  = load_data.hit;
         index_in = load_data.base_index;
         data_in  = load_data;
      end else if (fire) begin
         mask_in  = mask_ff & ~sel;
         index_in = index_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      data_ff  <= data_in;
   end

   `AST_IMPL(a_load_when_free, clock, reset, load, (mask_ff == '0) || (fire && last))
   `AST_IMPL(a_single_pick, clock, reset, rsp.valid, $onehot(sel))
   `AST_NEXT(a_run_ends, clock, reset, fire && last && !load, !rsp.valid)

endmodule

[rtl/adrp_pair_reference_scan_top.sv]
// top level of the adrp pair reference scanner
// depends on adrps_pkg, adrps_if, adrps_window and adrps_emit
//
// Usage:
//  req_ch carries one instruction word per transfer (valid/ready); last_word
//  marks the final word of a region, after which open windows are dropped,
//  the word address returns to the region base and the reference index
//  restarts at zero.
//  rsp_ch carries one matched adrp pair per transfer; last_of_run flags the
//  final result caused by one input word.
//  csr_* writes a register on any cycle with csr_write_enable high; the user
//  must write only while the block is idle, which the block does not enforce;
//  writing the region base also reloads the current word address.
//  A word is taken into the input register; its matches move on to the result
//  register, which offers them, once that register can take them. Words pass at
//  one word per cycle while none waits. A word that closes k windows holds the
//  result register until its k results are taken, and a next word that also
//  closes windows waits. A stalled receiver holds the result register and the
//  input register fills behind it; words that close nothing still pass.
//  Reset clears all windows and the counters and sets the configuration to defaults.
module adrp_pair_reference_scan_top #(
   parameter int WINDOW = adrps_pkg::WINDOW_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [adrps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                       csr_write_data,
   adrps_req_if.sink                         req_ch,
   adrps_rsp_if.source                       rsp_ch
);

   adrps_pkg::cfg_type  cfg_ff, cfg_in;
   logic [63:0]         base_ff, base_in;
   logic [63:0]         pc_ff, pc_in;
   logic [31:0]         count_ff, count_in;
   logic                word_valid_ff, word_valid_in;
   logic [31:0]         word_ff, word_in;
   logic                last_ff, last_in;

   adrps_pkg::hits_type hits;
   logic                hit_any;
   logic                can_load;
   logic                advance;
   logic                accept;

   assign advance      = word_valid_ff && (!hit_any || can_load);
   assign req_ch.ready = !word_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      cfg_in        = cfg_ff;
      base_in       = base_ff;
      pc_in         = pc_ff;
      count_in      = count_ff;
      word_valid_in = word_valid_ff;
      word_in       = word_ff;
      last_in       = last_ff;
      if (advance) begin
         word_valid_in = 1'b0;
         if (last_ff) begin
            pc_in    = base_ff;
            count_in = '0;
         end else begin
            pc_in    = pc_ff + 64'd4;
            count_in = count_ff + 32'($countones(hits.hit));
         end
      end
      if (accept) begin
         word_valid_in = 1'b1;
         word_in       = req_ch.insn_word;
         last_in       = req_ch.last_word;
      end
      if (csr_write_enable) begin
         case (csr_index)
            adrps_pkg::CSR_REGION_BASE: begin
               base_in = csr_write_data;
               pc_in   = csr_write_data;
            end
            adrps_pkg::CSR_WANTED_TARGET: begin
               cfg_in.wanted_target = csr_write_data;
            end
            adrps_pkg::CSR_FOLLOWER_KIND: begin
               cfg_in.follower_kind = csr_write_data[0];
            end
            adrps_pkg::CSR_MATCH_ANY: begin
               cfg_in.match_any_target = csr_write_data[0];
            end
            adrps_pkg::CSR_WANTED_REG: begin
               cfg_in.wanted_register = csr_write_data[5:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wanted_target    <= '0;
         cfg_ff.follower_kind    <= adrps_pkg::FOLLOW_ADD;
         cfg_ff.match_any_target <= 1'b0;
         cfg_ff.wanted_register  <= 6'h3f;
         base_ff                 <= '0;
         pc_ff                   <= '0;
         count_ff                <= '0;
         word_valid_ff           <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         base_ff       <= base_in;
         pc_ff         <= pc_in;
         count_ff      <= count_in;
         word_valid_ff <= word_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   adrps_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .word       (word_ff),
      .pc         (pc_ff),
      .index_base (count_ff),
      .commit     (advance),
      .last       (last_ff),
      .hits       (hits),
      .hit_any    (hit_any)
   );

   adrps_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && hit_any),
      .load_data (hits),
      .can_load  (can_load),
      .rsp       (rsp_ch)
   );

endmodule
